FILE: hdl/tc16_pkg.sv
package tc16_pkg;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_READ  = 2'd1,
      OP_WRITE = 2'd2,
      OP_ACK   = 2'd3
   } op_type;

   localparam logic [7:0] ADDR_CONTROL_A    = 8'h80;
   localparam logic [7:0] ADDR_CONTROL_B    = 8'h81;
   localparam logic [7:0] ADDR_CONTROL_C    = 8'h82;
   localparam logic [7:0] ADDR_COUNT_LOW    = 8'h84;
   localparam logic [7:0] ADDR_COUNT_HIGH   = 8'h85;
   localparam logic [7:0] ADDR_CAPTURE_LOW  = 8'h86;
   localparam logic [7:0] ADDR_CAPTURE_HIGH = 8'h87;
   localparam logic [7:0] ADDR_COMPARE_A_LO = 8'h88;
   localparam logic [7:0] ADDR_COMPARE_A_HI = 8'h89;
   localparam logic [7:0] ADDR_COMPARE_B_LO = 8'h8a;
   localparam logic [7:0] ADDR_COMPARE_B_HI = 8'h8b;
   localparam logic [7:0] ADDR_INT_MASK     = 8'h6f;
   localparam logic [7:0] ADDR_INT_FLAGS    = 8'h36;

   localparam logic [1:0] ACK_CAPTURE   = 2'd0;
   localparam logic [1:0] ACK_COMPARE_A = 2'd1;
   localparam logic [1:0] ACK_COMPARE_B = 2'd2;
   localparam logic [1:0] ACK_OVERFLOW  = 2'd3;

   localparam int FLAG_OVF  = 0;
   localparam int FLAG_CMPA = 1;
   localparam int FLAG_CMPB = 2;
   localparam int FLAG_CAPT = 5;

   localparam logic [3:0] MODE_RESERVED = 4'd13;

   localparam logic [15:0] COUNT_MAX = 16'hffff;

   typedef struct packed {
      logic       irq_overflow;
      logic       irq_compare_b;
      logic       irq_compare_a;
      logic       irq_capture;
      logic [7:0] read_data;
   } result_type;

endpackage

FILE: hdl/tc16_core.sv
module tc16_core
   import tc16_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  op_type     op,
   input  logic [7:0] address,
   input  logic [7:0] write_data,
   input  logic [1:0] ack_source,
   output result_type result
);

   logic [7:0]  control_a_ff, control_a_in;
   logic [7:0]  control_b_ff, control_b_in;
   logic [7:0]  control_c_ff, control_c_in;
   logic [7:0]  latch_ff, latch_in;
   logic [15:0] count_ff, count_in;
   logic [15:0] compare_a_ff, compare_a_in;
   logic [15:0] compare_b_ff, compare_b_in;
   logic [15:0] capture_ff, capture_in;
   logic [7:0]  mask_ff, mask_in;
   logic [7:0]  flags_ff, flags_in;
   logic [9:0]  prescale_ff, prescale_in;

   logic [3:0]  mode;
   logic [15:0] top_value;
   logic [15:0] ovf_value;
   logic        mode_ok;
   logic [10:0] divider;
   logic [10:0] prescale_plus;
   logic [15:0] count_step;
   logic [15:0] word;
   logic [7:0]  rd;
   logic [7:0]  active;

   always_comb begin
      mode = {control_b_ff[4:3], control_a_ff[1:0]};
      mode_ok = 1'b1;
      top_value = COUNT_MAX;
      ovf_value = COUNT_MAX;
      unique case (mode)
         4'd0: begin top_value = COUNT_MAX; ovf_value = COUNT_MAX; end
         4'd1: begin top_value = 16'h00ff; ovf_value = 16'h0000; end
         4'd2: begin top_value = 16'h01ff; ovf_value = 16'h0000; end
         4'd3: begin top_value = 16'h03ff; ovf_value = 16'h0000; end
         4'd4: begin top_value = compare_a_ff; ovf_value = COUNT_MAX; end
         4'd5: begin top_value = 16'h00ff; ovf_value = 16'h00ff; end
         4'd6: begin top_value = 16'h01ff; ovf_value = 16'h01ff; end
         4'd7: begin top_value = 16'h03ff; ovf_value = 16'h03ff; end
         4'd8: begin top_value = capture_ff; ovf_value = 16'h0000; end
         4'd9: begin top_value = compare_a_ff; ovf_value = 16'h0000; end
         4'd10: begin top_value = capture_ff; ovf_value = 16'h0000; end
         4'd11: begin top_value = compare_a_ff; ovf_value = 16'h0000; end
         4'd12: begin top_value = capture_ff; ovf_value = COUNT_MAX; end
         4'd14: begin top_value = capture_ff; ovf_value = capture_ff; end
         4'd15: begin top_value = compare_a_ff; ovf_value = compare_a_ff; end
         default: mode_ok = 1'b0;
      endcase

      unique case (control_b_ff[2:0])
         3'd0: divider = 11'd0;
         3'd1: divider = 11'd1;
         3'd2: divider = 11'd8;
         3'd3: divider = 11'd64;
         3'd4: divider = 11'd256;
         default: divider = 11'd1024;
      endcase

      prescale_plus = {1'b0, prescale_ff} + 11'd1;
      count_step = ((count_ff == top_value) || (count_ff == COUNT_MAX)) ? 16'h0000
                   : count_ff + 16'd1;
      word = {latch_ff, write_data};

      control_a_in = control_a_ff;
      control_b_in = control_b_ff;
      control_c_in = control_c_ff;
      latch_in     = latch_ff;
      count_in     = count_ff;
      compare_a_in = compare_a_ff;
      compare_b_in = compare_b_ff;
      capture_in   = capture_ff;
      mask_in      = mask_ff;
      flags_in     = flags_ff;
      prescale_in  = prescale_ff;
      rd           = 8'h00;

      if (step) begin
         unique case (op)
            OP_TICK: begin
               if (divider == 11'd0) begin
                  prescale_in = 10'd0;
               end else if (prescale_plus >= divider) begin
                  prescale_in = 10'd0;
                  if (mode_ok) begin
                     if (count_ff == compare_a_ff) flags_in[FLAG_CMPA] = 1'b1;
                     if (count_ff == compare_b_ff) flags_in[FLAG_CMPB] = 1'b1;
                     if (count_ff == ovf_value) flags_in[FLAG_OVF] = 1'b1;
                     count_in = count_step;
                  end
               end else begin
                  prescale_in = prescale_plus[9:0];
               end
            end
            OP_READ: begin
               unique case (address)
                  ADDR_CONTROL_A: rd = control_a_ff;
                  ADDR_CONTROL_B: rd = control_b_ff;
                  ADDR_CONTROL_C: rd = control_c_ff;
                  ADDR_COUNT_LOW: begin
                     latch_in = count_ff[15:8];
                     rd = count_ff[7:0];
                  end
                  ADDR_CAPTURE_LOW: begin
                     latch_in = capture_ff[15:8];
                     rd = capture_ff[7:0];
                  end
                  ADDR_COUNT_HIGH, ADDR_CAPTURE_HIGH: rd = latch_ff;
                  ADDR_COMPARE_A_LO: rd = compare_a_ff[7:0];
                  ADDR_COMPARE_A_HI: rd = compare_a_ff[15:8];
                  ADDR_COMPARE_B_LO: rd = compare_b_ff[7:0];
                  ADDR_COMPARE_B_HI: rd = compare_b_ff[15:8];
                  ADDR_INT_MASK: rd = mask_ff;
                  ADDR_INT_FLAGS: rd = flags_ff;
                  default: rd = 8'h00;
               endcase
            end
            OP_WRITE: begin
               unique case (address)
                  ADDR_CONTROL_A: control_a_in = write_data;
                  ADDR_CONTROL_B: control_b_in = write_data;
                  ADDR_CONTROL_C: control_c_in = write_data;
                  ADDR_COUNT_LOW: count_in = word;
                  ADDR_CAPTURE_LOW: capture_in = word;
                  ADDR_COMPARE_A_LO: compare_a_in = word;
                  ADDR_COMPARE_B_LO: compare_b_in = word;
                  ADDR_COUNT_HIGH, ADDR_CAPTURE_HIGH, ADDR_COMPARE_A_HI,
                  ADDR_COMPARE_B_HI: latch_in = write_data;
                  ADDR_INT_MASK: mask_in = write_data;
                  ADDR_INT_FLAGS: flags_in = flags_ff & ~write_data;
                  default: ;
               endcase
            end
            OP_ACK: begin
               unique case (ack_source)
                  ACK_CAPTURE: flags_in[FLAG_CAPT] = 1'b0;
                  ACK_COMPARE_A: flags_in[FLAG_CMPA] = 1'b0;
                  ACK_COMPARE_B: flags_in[FLAG_CMPB] = 1'b0;
                  ACK_OVERFLOW: flags_in[FLAG_OVF] = 1'b0;
                  default: ;
               endcase
            end
            default: ;
         endcase
      end

      active = flags_in & mask_in;
      result.read_data     = rd;
      result.irq_capture   = active[FLAG_CAPT];
      result.irq_compare_a = active[FLAG_CMPA];
      result.irq_compare_b = active[FLAG_CMPB];
      result.irq_overflow  = active[FLAG_OVF];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         control_a_ff <= '0;
         control_b_ff <= '0;
         control_c_ff <= '0;
         latch_ff     <= '0;
         count_ff     <= '0;
         compare_a_ff <= '0;
         compare_b_ff <= '0;
         capture_ff   <= '0;
         mask_ff      <= '0;
         flags_ff     <= '0;
         prescale_ff  <= '0;
      end else begin
         control_a_ff <= control_a_in;
         control_b_ff <= control_b_in;
         control_c_ff <= control_c_in;
         latch_ff     <= latch_in;
         count_ff     <= count_in;
         compare_a_ff <= compare_a_in;
         compare_b_ff <= compare_b_in;
         capture_ff   <= capture_in;
         mask_ff      <= mask_in;
         flags_ff     <= flags_in;
         prescale_ff  <= prescale_in;
      end
   end

endmodule

FILE: hdl/timer_counter_16bit_waveform_modes_unit.sv
// A request is taken into the request register, then moves into the response register.
// Throughput: one request per cycle unless the response side stalls; the request register
// moves whenever the response register is empty or being taken; a response stall holds one.
// Reset: synchronous and active high; it empties both registers and clears all
// timer registers, flags and the prescaler to zero.
module timer_counter_16bit_waveform_modes_unit
   import tc16_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // address[7:0], write_data[15:8], ack_source[17:16]
   input  logic [1:0]  req_tuser,  // operation[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata   // read_data[7:0], irq_capture[8], irq_compare_a[9],
                                   // irq_compare_b[10], irq_overflow[11]
);

   logic       in_valid_ff;
   op_type     op_ff;
   logic [7:0] addr_ff;
   logic [7:0] data_ff;
   logic [1:0] src_ff;
   logic       rsp_valid_ff;
   result_type rsp_data_ff;
   result_type core_result;
   logic       move;

   assign move       = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || move;

   tc16_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (move),
      .op         (op_ff),
      .address    (addr_ff),
      .write_data (data_ff),
      .ack_source (src_ff),
      .result     (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (move) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_tvalid && req_tready) begin
         op_ff   <= op_type'(req_tuser);
         addr_ff <= req_tdata[7:0];
         data_ff <= req_tdata[15:8];
         src_ff  <= req_tdata[17:16];
      end
      if (move) begin
         rsp_data_ff <= core_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_data_ff};

   a_move_fills_response: assert property (@(posedge clock) disable iff (reset)
      move |=> rsp_tvalid)
      else $error("response register not filled after a request moved");

   a_blocked_request_held: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !move) |=> (in_valid_ff && $stable(addr_ff) && $stable(data_ff)))
      else $error("blocked request lost from the request register");

   a_read_data_only_on_read: assert property (@(posedge clock) disable iff (reset)
      (move && op_ff != OP_READ) |=> (rsp_tdata[7:0] == 8'h00))
      else $error("nonzero read data on a request that is not a read");

endmodule
